[rtl/core/scba_pkg.sv]
package scba_pkg;

    localparam int NUM_CLASSES_DEF        = 9;
    localparam int MIN_BLOCK_BYTES_DEF    = 8;
    localparam int FIRST_CLASS_BLOCKS_DEF = 4;

    // Free map word width
    localparam int WORD_BITS = 32;
    localparam int BSEL_W    = $clog2(WORD_BITS);

    localparam int FUNC_FW   = 1;
    localparam int BYTES_FW  = 16;
    localparam int CLASS_FW  = 4;
    localparam int SLOT_FW   = 10;
    localparam int STATUS_FW = 3;
    localparam int LEFT_FW   = 11;

    localparam logic [CLASS_FW-1:0] CFG_CLASSES_RESET = 4'd9;

    localparam logic [FUNC_FW-1:0] FUNC_ALLOC = 1'b0;
    localparam logic [FUNC_FW-1:0] FUNC_FREE  = 1'b1;

    typedef logic [STATUS_FW-1:0] status_t;

    localparam status_t ST_ALLOC   = 3'd0;
    localparam status_t ST_FREED   = 3'd1;
    localparam status_t ST_NOFIT   = 3'd2;
    localparam status_t ST_ALREADY = 3'd3;
    localparam status_t ST_BAD     = 3'd4;

    typedef struct packed {
        logic [FUNC_FW-1:0]  func;
        logic [BYTES_FW-1:0] request_bytes;
        logic                handle_present;
        logic [CLASS_FW-1:0] handle_class;
        logic [SLOT_FW-1:0]  handle_slot;
    } req_t;

    typedef struct packed {
        status_t             status;
        logic [CLASS_FW-1:0] granted_class;
        logic [SLOT_FW-1:0]  granted_slot;
        logic [LEFT_FW-1:0]  class_free_left;
    } res_t;

    typedef struct packed {
        logic    clr_step;
        logic    load;
        logic    start_op;
        logic    rd_en;
        logic    advance;
        logic    finish;
        status_t code;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic is_free;
        logic alloc_found;
        logic handle_ok;
        logic word_hit;
        logic bit_free;
    } stat_t;

    // First free-map bit of class k
    function automatic int class_base(int first_blocks, int k);
        return first_blocks * ((1 << k) - 1);
    endfunction

endpackage

[rtl/core/size_class_block_allocator.sv]
// Size-class block allocator. A request is taken when start is high and busy
// is low; its result appears on result for one cycle with done high and must
// be captured then, since the block cannot be held off. After reset the free
// map is swept to all-free one 32-bit word per cycle with busy high;
// configuration writes are taken meanwhile. Start to next start: a failed
// allocate or a bad or null free takes decode only, a free decode, read and
// check, and an allocate decode, read and one check per 32-bit map word
// scanned in the chosen class, since the single map read port returns one
// word per cycle. done rises the cycle after the request completes.
module size_class_block_allocator
    import scba_pkg::*;
#(
    parameter int NUM_CLASSES        = NUM_CLASSES_DEF,
    parameter int MIN_BLOCK_BYTES    = MIN_BLOCK_BYTES_DEF,
    parameter int FIRST_CLASS_BLOCKS = FIRST_CLASS_BLOCKS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  req_t                req,
    input  logic                cfg_we,
    input  logic [CLASS_FW-1:0] cfg_wdata,
    output logic                done,
    output res_t                result
);

    cmd_t  cmd;
    stat_t stat;

    scba_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    scba_datapath #(
        .NUM_CLASSES        (NUM_CLASSES),
        .MIN_BLOCK_BYTES    (MIN_BLOCK_BYTES),
        .FIRST_CLASS_BLOCKS (FIRST_CLASS_BLOCKS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat),
        .done      (done),
        .result    (result)
    );

endmodule

[rtl/core/scba_ctrl.sv]
module scba_ctrl
    import scba_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    output logic  busy,
    input  stat_t stat,
    output cmd_t  cmd
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_DECODE = 3'd2;
    localparam logic [2:0] S_READ   = 3'd3;
    localparam logic [2:0] S_CHECK  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.code   = ST_BAD;
        busy       = 1'b1;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (!stat.is_free)
                begin
                    if (stat.alloc_found)
                    begin
                        cmd.start_op = 1'b1;
                        state_next   = S_READ;
                    end
                    else
                    begin
                        cmd.finish = 1'b1;
                        cmd.code   = ST_NOFIT;
                        state_next = S_IDLE;
                    end
                end
                else if (stat.handle_ok)
                begin
                    cmd.start_op = 1'b1;
                    state_next   = S_READ;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    cmd.code   = ST_BAD;
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (!stat.is_free)
                begin
                    if (stat.word_hit)
                    begin
                        cmd.finish = 1'b1;
                        cmd.code   = ST_ALLOC;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        // try the next map word of this class
                        cmd.advance = 1'b1;
                    end
                end
                else
                begin
                    cmd.finish = 1'b1;
                    cmd.code   = stat.bit_free ? ST_ALREADY : ST_FREED;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

[rtl/core/scba_datapath.sv]
module scba_datapath
    import scba_pkg::*;
#(
    parameter int NUM_CLASSES        = NUM_CLASSES_DEF,
    parameter int MIN_BLOCK_BYTES    = MIN_BLOCK_BYTES_DEF,
    parameter int FIRST_CLASS_BLOCKS = FIRST_CLASS_BLOCKS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  req_t                req,
    input  logic                cfg_we,
    input  logic [CLASS_FW-1:0] cfg_wdata,
    input  cmd_t                cmd,
    output stat_t               stat,
    output logic                done,
    output res_t                result
);

    localparam int TOTAL_BITS = FIRST_CLASS_BLOCKS * ((1 << NUM_CLASSES) - 1);
    localparam int WORDS      = (TOTAL_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W     = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int IDX_W      = ADDR_W + BSEL_W;
    localparam int CLS_W      = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int MAX_BLOCKS = FIRST_CLASS_BLOCKS << (NUM_CLASSES - 1);
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

    localparam logic [BSEL_W-1:0] BSEL_MAX = BSEL_W'(WORD_BITS - 1);
    localparam logic [WORD_BITS-1:0] ONES  = {WORD_BITS{1'b1}};

    logic [WORD_BITS-1:0] mem [WORDS];
    logic [WORD_BITS-1:0] rd_data_reg;

    req_t                 req_reg;
    logic [CLASS_FW-1:0]  cfg_reg;
    logic [CNT_W-1:0]     cnt_reg [NUM_CLASSES];
    logic [ADDR_W-1:0]    clr_addr_reg;
    logic [CLS_W-1:0]     cls_reg;
    logic [ADDR_W-1:0]    ptr_reg;
    logic [BSEL_W-1:0]    bitsel_reg;
    logic [IDX_W-1:0]     first_bit_reg;
    logic [IDX_W-1:0]     last_bit_reg;
    logic                 done_reg;
    res_t                 res_reg;

    logic                 alloc_found;
    logic [CLS_W-1:0]     alloc_cls;
    logic                 handle_ok;
    logic [CLS_W-1:0]     sel_cls;
    logic [IDX_W-1:0]     sel_base;
    logic [IDX_W-1:0]     sel_blocks;
    logic [IDX_W-1:0]     free_idx;

    logic [WORD_BITS-1:0] scan_mask;
    logic [WORD_BITS-1:0] scan_bits;
    logic [BSEL_W-1:0]    hit_pos;
    logic [IDX_W-1:0]     alloc_slot;
    logic [CNT_W-1:0]     cnt_sel;

    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic [ADDR_W-1:0]    rd_addr;
    res_t                 res_next;

    // Class pick for an allocate: lowest class that fits and has a free block
    always_comb
    begin
        alloc_found = 1'b0;
        alloc_cls   = '0;
        for (int k = NUM_CLASSES - 1; k >= 0; k--)
        begin
            if ((CLASS_FW'(k) < cfg_reg) &&
                (int'(req_reg.request_bytes) <= (MIN_BLOCK_BYTES << k)) &&
                (cnt_reg[k] != '0))
            begin
                alloc_found = 1'b1;
                alloc_cls   = CLS_W'(k);
            end
        end
    end

    always_comb
    begin
        handle_ok = 1'b0;
        if (req_reg.handle_present &&
            (int'(req_reg.handle_class) < NUM_CLASSES))
        begin
            handle_ok = int'(req_reg.handle_slot) <
                        (FIRST_CLASS_BLOCKS << req_reg.handle_class);
        end
    end

    assign sel_cls    = (req_reg.func == FUNC_FREE) ? req_reg.handle_class[CLS_W-1:0]
                                                    : alloc_cls;
    assign sel_base   = IDX_W'(class_base(FIRST_CLASS_BLOCKS, int'(sel_cls)));
    assign sel_blocks = IDX_W'(FIRST_CLASS_BLOCKS << sel_cls);
    assign free_idx   = sel_base + IDX_W'(req_reg.handle_slot);

    // Restrict the scanned word to the bits of the chosen class
    always_comb
    begin
        scan_mask = ONES;
        if (ptr_reg == first_bit_reg[IDX_W-1:BSEL_W])
        begin
            scan_mask = scan_mask & (ONES << first_bit_reg[BSEL_W-1:0]);
        end
        if (ptr_reg == last_bit_reg[IDX_W-1:BSEL_W])
        begin
            scan_mask = scan_mask & (ONES >> (BSEL_MAX - last_bit_reg[BSEL_W-1:0]));
        end
        scan_bits = rd_data_reg & scan_mask;
        hit_pos   = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (scan_bits[i])
            begin
                hit_pos = BSEL_W'(i);
            end
        end
    end

    assign alloc_slot = {ptr_reg, hit_pos} - first_bit_reg;
    assign cnt_sel    = cnt_reg[cls_reg];

    assign stat.clr_last    = (clr_addr_reg == ADDR_W'(WORDS - 1));
    assign stat.is_free     = (req_reg.func == FUNC_FREE);
    assign stat.alloc_found = alloc_found;
    assign stat.handle_ok   = handle_ok;
    assign stat.word_hit    = |scan_bits;
    assign stat.bit_free    = rd_data_reg[bitsel_reg];

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = ptr_reg;
        wr_data = rd_data_reg;
        if (cmd.clr_step)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_reg;
            wr_data = ONES;
        end
        else if (cmd.finish && (cmd.code == ST_ALLOC))
        begin
            wr_en   = 1'b1;
            wr_data = rd_data_reg & ~(WORD_BITS'(1) << hit_pos);
        end
        else if (cmd.finish && (cmd.code == ST_FREED))
        begin
            wr_en   = 1'b1;
            wr_data = rd_data_reg | (WORD_BITS'(1) << bitsel_reg);
        end
    end

    assign rd_addr = cmd.advance ? (ptr_reg + ADDR_W'(1)) : ptr_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en || cmd.advance)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        res_next = '0;
        res_next.status = cmd.code;
        case (cmd.code)
            ST_ALLOC:
            begin
                res_next.granted_class   = CLASS_FW'(cls_reg);
                res_next.granted_slot    = SLOT_FW'(alloc_slot);
                res_next.class_free_left = LEFT_FW'(cnt_sel - CNT_W'(1));
            end
            ST_FREED:
            begin
                res_next.granted_class   = req_reg.handle_class;
                res_next.granted_slot    = req_reg.handle_slot;
                res_next.class_free_left = LEFT_FW'(cnt_sel + CNT_W'(1));
            end
            ST_ALREADY:
            begin
                res_next.granted_class   = req_reg.handle_class;
                res_next.granted_slot    = req_reg.handle_slot;
                res_next.class_free_left = LEFT_FW'(cnt_sel);
            end
            default:
            begin
                res_next.status = cmd.code;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
        if (cmd.start_op)
        begin
            cls_reg       <= sel_cls;
            first_bit_reg <= sel_base;
            last_bit_reg  <= sel_base + sel_blocks - IDX_W'(1);
            bitsel_reg    <= free_idx[BSEL_W-1:0];
            ptr_reg       <= stat.is_free ? free_idx[IDX_W-1:BSEL_W]
                                          : sel_base[IDX_W-1:BSEL_W];
        end
        else if (cmd.advance)
        begin
            ptr_reg <= ptr_reg + ADDR_W'(1);
        end
        if (cmd.finish)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg      <= CFG_CLASSES_RESET;
            clr_addr_reg <= '0;
            done_reg     <= 1'b0;
            for (int k = 0; k < NUM_CLASSES; k++)
            begin
                cnt_reg[k] <= CNT_W'(FIRST_CLASS_BLOCKS << k);
            end
        end
        else
        begin
            done_reg <= cmd.finish;
            if (cfg_we)
            begin
                cfg_reg <= cfg_wdata;
            end
            if (cmd.clr_step)
            begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end
            if (cmd.finish && (cmd.code == ST_ALLOC))
            begin
                cnt_reg[cls_reg] <= cnt_sel - CNT_W'(1);
            end
            else if (cmd.finish && (cmd.code == ST_FREED))
            begin
                cnt_reg[cls_reg] <= cnt_sel + CNT_W'(1);
            end
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

[rtl/core/scba_checker.sv]
module scba_checker
    import scba_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input res_t result
);

    // a result only closes a transaction that kept the block busy
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a transaction in progress");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("two results in consecutive cycles");

    a_fail_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && ((result.status == ST_NOFIT) || (result.status == ST_BAD))) |->
        ((result.granted_class == '0) && (result.granted_slot == '0) &&
         (result.class_free_left == '0)))
        else $error("failed transaction carries nonzero fields");

endmodule

bind size_class_block_allocator scba_checker u_scba_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
